// ===== design/fpa_pkg.sv =====
// Shared types and mode codes for the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;

    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_SUB  = 4'd1;
    localparam logic [3:0] MODE_MUL  = 4'd2;
    localparam logic [3:0] MODE_DIV  = 4'd3;
    localparam logic [3:0] MODE_GT   = 4'd4;
    localparam logic [3:0] MODE_LT   = 4'd5;
    localparam logic [3:0] MODE_GE   = 4'd6;
    localparam logic [3:0] MODE_LE   = 4'd7;
    localparam logic [3:0] MODE_EQ   = 4'd8;
    localparam logic [3:0] MODE_NE   = 4'd9;
    localparam logic [3:0] MODE_FROM = 4'd10;
    localparam logic [3:0] MODE_TO   = 4'd11;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_flag;
        logic               error_flag;
    } fpa_rsp_t;

    // Control and divider state that travels down the pipeline with each word.
    typedef struct packed {
        logic        valid;
        logic [3:0]  mode;
        logic [31:0] simple_res;
        logic        cmp;
        logic        a_neg;
        logic        q_neg;
        logic        b_zero;
        logic [31:0] divisor;
        logic [31:0] rem;
    } fpa_ctl_t;

endpackage

// ===== design/fpa_div_stage.sv =====
// One restoring-division step of the pipelined divider.
module fpa_div_stage
    import fpa_pkg::*;
#(
    parameter int W = 32 + FRAC_BITS_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  fpa_ctl_t       ctl_in,
    input  logic [W-1:0]   dq_in,
    output fpa_ctl_t       ctl_out,
    output logic [W-1:0]   dq_out
);

    fpa_ctl_t     ctl_reg, ctl_next;
    logic         valid_reg;
    logic [W-1:0] dq_reg, dq_next;
    logic [32:0]  trial;
    logic [32:0]  diff;
    logic         fits;

    always_comb
    begin
        trial    = {ctl_in.rem, dq_in[W-1]};
        diff     = trial - {1'b0, ctl_in.divisor};
        fits     = trial >= {1'b0, ctl_in.divisor};
        ctl_next = ctl_in;
        ctl_next.rem = fits ? diff[31:0] : trial[31:0];
        dq_next  = {dq_in[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg <= ctl_next;
            dq_reg  <= dq_next;
        end
    end

    // The valid bit is the top field of the control word.
    assign ctl_out = {valid_reg, ctl_reg[$bits(fpa_ctl_t)-2:0]};
    assign dq_out  = dq_reg;

endmodule

// ===== design/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | fpa_req_t (mode, operand_a, operand_b)
//  rsp     | out       | rsp_valid/rsp_stall | fpa_rsp_t (result, compare, error)
//
// One word enters per cycle while req_stall is low; every word passes stage one,
// stage two, the divider (one quotient bit per stage over 32 + FRAC_BITS stages)
// and the output register, and every mode flows through the same depth.
// Reset clears only the valid bits of the stages and of the output register.
// When the output register holds a word that the receiver stalls, the whole
// pipeline freezes and req_stall is raised; nothing is dropped or repeated.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  fpa_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output fpa_rsp_t rsp_data
);

    // Quotient width: |a| * 2^FRAC_BITS needs 32 + FRAC_BITS bits.
    localparam int W = 32 + FRAC_BITS;
    localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

    logic advance;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance   = !(rsp_valid && rsp_stall);
    assign req_stall = !advance;

    // Stage one: decode, the simple modes, the multiplier and divider setup.
    fpa_ctl_t            s1_ctl_reg, s1_ctl_next;
    logic                s1_valid_reg;
    logic [W-1:0]        s1_dq_reg, s1_dq_next;
    logic signed [63:0]  s1_prod_reg, s1_prod_next;
    logic [31:0]         a_mag;
    logic signed [31:0]  a_s, b_s;

    always_comb
    begin
        a_s          = req_data.operand_a;
        b_s          = req_data.operand_b;
        a_mag        = a_s[31] ? (32'd0 - a_s) : a_s;
        s1_prod_next = 64'(a_s) * 64'(b_s);
        s1_dq_next   = W'(a_mag) << FRAC_BITS;
        s1_ctl_next            = '0;
        s1_ctl_next.valid      = req_valid;
        s1_ctl_next.mode       = req_data.mode;
        s1_ctl_next.a_neg      = a_s[31];
        s1_ctl_next.q_neg      = a_s[31] ^ b_s[31];
        s1_ctl_next.b_zero     = (b_s == 32'sd0);
        s1_ctl_next.divisor    = b_s[31] ? (32'd0 - b_s) : b_s;
        s1_ctl_next.rem        = '0;
        unique case (req_data.mode)
            MODE_ADD:  s1_ctl_next.simple_res = a_s + b_s;
            MODE_SUB:  s1_ctl_next.simple_res = a_s - b_s;
            MODE_GT:   s1_ctl_next.cmp = a_s >  b_s;
            MODE_LT:   s1_ctl_next.cmp = a_s <  b_s;
            MODE_GE:   s1_ctl_next.cmp = a_s >= b_s;
            MODE_LE:   s1_ctl_next.cmp = a_s <= b_s;
            MODE_EQ:   s1_ctl_next.cmp = a_s == b_s;
            MODE_NE:   s1_ctl_next.cmp = a_s != b_s;
            MODE_FROM: s1_ctl_next.simple_res = a_s << FRAC_BITS;
            MODE_TO:   s1_ctl_next.simple_res = a_s >>> FRAC_BITS;
            default:   s1_ctl_next.simple_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg  <= s1_ctl_next;
            s1_dq_reg   <= s1_dq_next;
            s1_prod_reg <= s1_prod_next;
        end
    end

    // Stage two: the product is divided by 2^FRAC_BITS toward zero, which
    // means adding 2^FRAC_BITS - 1 to a negative product before the shift.
    fpa_ctl_t           ctl_pipe [0:W];
    logic [W-1:0]       dq_pipe  [0:W];
    fpa_ctl_t           s2_ctl_reg, s2_ctl_next;
    logic               s2_valid_reg;
    logic [W-1:0]       s2_dq_reg;
    logic signed [63:0] prod_adj;
    logic signed [63:0] prod_q;

    always_comb
    begin
        prod_adj    = s1_prod_reg + (s1_prod_reg[63] ? $signed(RND) : 64'sd0);
        prod_q      = prod_adj >>> FRAC_BITS;
        s2_ctl_next = s1_ctl_reg;
        s2_ctl_next.valid = s1_valid_reg;
        if (s1_ctl_reg.mode == MODE_MUL)
        begin
            s2_ctl_next.simple_res = prod_q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s2_ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_ctl_reg <= s2_ctl_next;
            s2_dq_reg  <= s1_dq_reg;
        end
    end

    // The valid bit is the top field of the control word.
    assign ctl_pipe[0] = {s2_valid_reg, s2_ctl_reg[$bits(fpa_ctl_t)-2:0]};
    assign dq_pipe[0]  = s2_dq_reg;

    // Divider chain: each stage shifts one dividend bit into the remainder
    // and one quotient bit into the bottom of the same word.
    for (genvar i = 0; i < W; i++)
    begin : g_div
        fpa_div_stage #(
            .W (W)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl_pipe[i]),
            .dq_in   (dq_pipe[i]),
            .ctl_out (ctl_pipe[i+1]),
            .dq_out  (dq_pipe[i+1])
        );
    end

    // Final stage: sign the quotient, saturate, and pick the result.
    fpa_ctl_t     fin;
    logic [W-1:0] qmag;
    logic         q_big;
    logic [31:0]  q_signed;
    fpa_rsp_t     rsp_next;
    fpa_rsp_t     rsp_reg;
    logic         rsp_valid_reg;

    always_comb
    begin
        fin      = ctl_pipe[W];
        qmag     = dq_pipe[W];
        q_signed = fin.q_neg ? (32'd0 - qmag[31:0]) : qmag[31:0];
        // A positive quotient may reach 2^31 - 1, a negative one 2^31.
        if (fin.q_neg)
        begin
            q_big = (qmag > W'(33'h080000000));
        end
        else
        begin
            q_big = (qmag > W'(33'h07FFFFFFF));
        end
        rsp_next.compare_flag = fin.cmp;
        rsp_next.error_flag   = 1'b0;
        rsp_next.result_value = fin.simple_res;
        if (fin.mode == MODE_DIV)
        begin
            if (fin.b_zero)
            begin
                rsp_next.error_flag   = 1'b1;
                rsp_next.result_value = fin.a_neg ? 32'h80000000 : 32'h7FFFFFFF;
            end
            else if (q_big)
            begin
                rsp_next.error_flag   = 1'b1;
                rsp_next.result_value = fin.q_neg ? 32'h80000000 : 32'h7FFFFFFF;
            end
            else
            begin
                rsp_next.result_value = q_signed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The input is held off only while a finished word waits at the output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("input stalled while output register free");

    // A comparison never carries an error, and an error never a comparison.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.compare_flag && rsp_data.error_flag))
        else $error("compare and error flags both set");

    // A saturated word always holds one of the two limits.
    a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.error_flag) |->
        (rsp_data.result_value == 32'h7FFFFFFF || rsp_data.result_value == 32'h80000000))
        else $error("error word is not saturated");

    // A true comparison reports a zero result.
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.compare_flag) |-> (rsp_data.result_value == 32'sd0))
        else $error("comparison word has nonzero result");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the pipelined signed fixed-point ALU.
module tb;
    import fpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEFAULT;
    // The pipeline is FRAC_BITS + 35 stages deep; the drain wait covers that with margin.
    localparam int DRAIN_CYCLES = FB + 60;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    fpa_req_t req_data;
    logic     rsp_valid;
    logic     rsp_stall;
    fpa_rsp_t rsp_data;

    fpa_rsp_t expected_words[$];
    int       failures;
    bit       sink_idle_allowed;
    bit       src_idle_allowed;

    fixed_point_alu #(.FRAC_BITS(FB)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Computes the result word that the ALU must return for one request word.
    function automatic fpa_rsp_t alu_result(fpa_req_t r);
        fpa_rsp_t   o;
        longint     sa;
        longint     sb;
        longint     q;
        logic [31:0] ua;
        sa = longint'(r.operand_a);
        sb = longint'(r.operand_b);
        ua = r.operand_a;
        o = '0;
        case (r.mode)
            MODE_ADD:  o.result_value = r.operand_a + r.operand_b;
            MODE_SUB:  o.result_value = r.operand_a - r.operand_b;
            MODE_MUL:
            begin
                // Division of a longint truncates toward zero, as the ALU's multiplier does.
                q = (sa * sb) / (longint'(1) <<< FB);
                o.result_value = q[31:0];
            end
            MODE_DIV:
            begin
                if (sb == 0)
                begin
                    o.error_flag = 1'b1;
                    o.result_value = (sa < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    q = (sa <<< FB) / sb;
                    if (q > longint'(32'sh7FFF_FFFF))
                    begin
                        o.error_flag = 1'b1;
                        o.result_value = 32'h7FFF_FFFF;
                    end
                    else if (q < -longint'(64'd2147483648))
                    begin
                        o.error_flag = 1'b1;
                        o.result_value = 32'h8000_0000;
                    end
                    else
                        o.result_value = q[31:0];
                end
            end
            MODE_GT:   o.compare_flag = sa > sb;
            MODE_LT:   o.compare_flag = sa < sb;
            MODE_GE:   o.compare_flag = sa >= sb;
            MODE_LE:   o.compare_flag = sa <= sb;
            MODE_EQ:   o.compare_flag = sa == sb;
            MODE_NE:   o.compare_flag = sa != sb;
            MODE_FROM: o.result_value = ua << FB;
            MODE_TO:   o.result_value = r.operand_a >>> FB;
            default:   o = '0;
        endcase
        return o;
    endfunction

    // Sends one request word, with an optional random idle burst first.
    // The valid stays high between back-to-back words, so it is never dropped and
    // raised again in the same step.
    task automatic send_word(logic [3:0] mode, logic [31:0] a, logic [31:0] b);
        int gap;
        fpa_req_t w;
        if (src_idle_allowed && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.mode = mode;
        w.operand_a = a;
        w.operand_b = b;
        req_valid <= 1'b1;
        req_data  <= w;
        // Accepted at the first edge with valid high and stall low.
        do
            @(posedge clk);
        while (req_stall);
        expected_words.push_back(alu_result(w));
    endtask

    task automatic idle_source();
        req_valid <= 1'b0;
    endtask

    // Random operand that favors edge values and small fixed-point numbers.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(0);
            3: return 32'($signed($urandom_range(0, 2048)) - 1024);
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // Response checker: compares each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        fpa_rsp_t exp_w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, rsp_data);
                failures++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (rsp_data.result_value !== exp_w.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             exp_w.result_value, rsp_data.result_value);
                    failures++;
                end
                if (rsp_data.compare_flag !== exp_w.compare_flag)
                begin
                    $display("%0t: compare_flag expected %b actual %b", $time,
                             exp_w.compare_flag, rsp_data.compare_flag);
                    failures++;
                end
                if (rsp_data.error_flag !== exp_w.error_flag)
                begin
                    $display("%0t: error_flag expected %b actual %b", $time,
                             exp_w.error_flag, rsp_data.error_flag);
                    failures++;
                end
            end
        end
    end

    // Receiver stall: random bursts, switched off for the final part.
    initial
    begin
        int burst;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_idle_allowed && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 12);
                rsp_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Directed corners: field extremes, every mode and the divider special cases.
    task automatic test_directed();
        send_word(MODE_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(MODE_SUB, 32'h8000_0000, 32'h0000_0001);
        send_word(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(MODE_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        send_word(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
        send_word(MODE_DIV, 32'h0000_0100, 32'h0);
        send_word(MODE_DIV, 32'h0, 32'h0);
        send_word(MODE_DIV, 32'hFFFF_FF00, 32'h0);
        send_word(MODE_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(MODE_DIV, 32'h8000_0000, 32'h0000_0100);
        send_word(MODE_DIV, 32'hFFFF_FD00, 32'h0000_0200);
        send_word(MODE_GT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(MODE_LT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(MODE_GE, 32'h0000_0005, 32'h0000_0005);
        send_word(MODE_LE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(MODE_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_FROM, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_FROM, 32'h8000_0001, 32'h0);
        send_word(MODE_TO, 32'h8000_0000, 32'h1234_5678);
        send_word(MODE_TO, 32'hFFFF_FFFF, 32'h0);
        send_word(4'd12, 32'h1234_5678, 32'h9ABC_DEF0);
        send_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Random words over all sixteen mode codes, with idling on both sides when allowed.
    task automatic test_random(int count);
        logic [3:0] m;
        repeat (count)
        begin
            m = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
            send_word(m, pick_operand(), ($urandom_range(0, 9) == 0) ? 32'h0 : pick_operand());
        end
    endtask

    // Last stretch with no idling, so the pipeline runs at full rate.
    task automatic test_full_rate(int count);
        src_idle_allowed = 1'b0;
        sink_idle_allowed = 1'b0;
        test_random(count);
    endtask

    initial
    begin
        int waited;
        failures = 0;
        src_idle_allowed = 1'b1;
        sink_idle_allowed = 1'b1;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(900);
        test_full_rate(250);
        idle_source();

        // Wait for every expected result, then give stray words time to show up.
        waited = 0;
        while (expected_words.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fpa_pkg.sv
design/fpa_div_stage.sv
design/fixed_point_alu.sv
bench/tb.sv
